// ===== rtl/rwfg_pkg.sv =====
// ----------------------------------------------------------------------------
// rwfg_pkg: rainbow wheel frame generator shared types and constants
// widths, pixel limits and the color wheel mapping
// ----------------------------------------------------------------------------
package rwfg_pkg;

  localparam int MAX_PIXELS = 64;
  localparam int IDX_W      = $clog2(MAX_PIXELS);
  localparam int CNT_W      = 7;
  localparam int LVL_W      = 8;
  localparam int POS_W      = 8;
  localparam int DIV_STEPS  = POS_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic MODE_RAINBOW = 1'b0;
  localparam logic MODE_SOLID   = 1'b1;

  localparam logic [0:0] REG_PIXEL_COUNT = 1'b0;

  localparam logic [POS_W-1:0] SEG_LEN    = 8'd85;
  localparam logic [POS_W-1:0] SEG_TWICE  = 8'd170;
  localparam logic [LVL_W-1:0] LVL_FULL   = 8'd255;

  typedef struct packed {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
  } rgb_t;

  function automatic rgb_t wheel_color(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] q;
    logic [POS_W-1:0] t;
    logic [9:0]       t3;
    logic [LVL_W-1:0] up;
    logic [LVL_W-1:0] down;
    rgb_t             c;
    q = LVL_FULL - pos;
    if (q < SEG_LEN) begin
      t = q;
    end else if (q < SEG_TWICE) begin
      t = q - SEG_LEN;
    end else begin
      t = q - SEG_TWICE;
    end
    t3   = {2'b00, t} + {1'b0, t, 1'b0};
    up   = t3[LVL_W-1:0];
    down = LVL_FULL - up;
    if (q < SEG_LEN) begin
      c.red = down; c.green = '0; c.blue = up;
    end else if (q < SEG_TWICE) begin
      c.red = '0; c.green = up; c.blue = down;
    end else begin
      c.red = up; c.green = down; c.blue = '0;
    end
    return c;
  endfunction

endpackage

// ===== rtl/rwfg_if.sv =====
// ----------------------------------------------------------------------------
// rwfg_in_if / rwfg_out_if: item channels of the frame generator
// valid/ready handshake carrying frame requests and pixel colors
// ----------------------------------------------------------------------------
interface rwfg_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [rwfg_pkg::LVL_W-1:0]     fill_red;
  logic [rwfg_pkg::LVL_W-1:0]     fill_green;
  logic [rwfg_pkg::LVL_W-1:0]     fill_blue;

  modport source (output valid, mode, fill_red, fill_green, fill_blue, input ready);
  modport sink   (input valid, mode, fill_red, fill_green, fill_blue, output ready);
endinterface

interface rwfg_out_if;
  logic                           valid;
  logic                           ready;
  logic [rwfg_pkg::IDX_W-1:0]     pixel_index;
  logic [rwfg_pkg::LVL_W-1:0]     pix_red;
  logic [rwfg_pkg::LVL_W-1:0]     pix_green;
  logic [rwfg_pkg::LVL_W-1:0]     pix_blue;
  logic                           last_pixel;

  modport source (output valid, pixel_index, pix_red, pix_green, pix_blue, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_index, pix_red, pix_green, pix_blue, last_pixel,
                  output ready);
endinterface

// ===== rtl/rainbow_wheel_frame_generator_top.sv =====
// ----------------------------------------------------------------------------
// rainbow_wheel_frame_generator_top: color wheel frame generator
// one frame request yields one color item per pixel, in pixel order
// ----------------------------------------------------------------------------
// each pixel runs the shared restoring divide step over all quotient bits, then
// waits in the output state until out_item.ready takes it; the first pixel item
// is valid once the divide steps for the first pixel are done after the request
// a new frame request is taken the cycle after the last pixel item leaves
// rst_n is synchronous, active low: pixel_count returns to 64, offset to 0
module rainbow_wheel_frame_generator_top (
  input  logic                   clk,
  input  logic                   rst_n,
  rwfg_in_if.sink                in_item,
  rwfg_out_if.source             out_item,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam int CW = rwfg_pkg::CNT_W;
  localparam int IW = rwfg_pkg::IDX_W;
  localparam int PW = rwfg_pkg::POS_W;
  localparam int SW = rwfg_pkg::STEP_W;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] pixel_count_r;
  logic [PW-1:0] offset_r, offset_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          mode_r, mode_nxt;
  rwfg_pkg::rgb_t fill_r, fill_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [PW-1:0] rem_r, rem_nxt;
  logic [PW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] step_r, step_nxt;
  rwfg_pkg::rgb_t pix_r, pix_nxt;
  logic          last_r, last_nxt;

  logic [CW-1:0] used_n;
  logic [PW-1:0] shifted;
  logic          ge;
  logic [PW-1:0] pos;
  rwfg_pkg::rgb_t wheel;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == rwfg_pkg::REG_PIXEL_COUNT) ?
                  {{(32-CW){1'b0}}, pixel_count_r} : 32'd0;

  always_comb begin
    if (pixel_count_r == '0) begin
      used_n = CW'(1);
    end else if (pixel_count_r > CW'(rwfg_pkg::MAX_PIXELS)) begin
      used_n = CW'(rwfg_pkg::MAX_PIXELS);
    end else begin
      used_n = pixel_count_r;
    end
  end

  // shared compare/subtract step of the restoring divider
  assign shifted = {rem_r[PW-2:0], 1'b0};
  assign ge      = shifted >= {{(PW-CW){1'b0}}, n_r};
  assign quo_nxt = {quo_r[PW-2:0], ge};
  assign pos     = quo_nxt + offset_r;
  assign wheel   = rwfg_pkg::wheel_color(pos);

  assign in_item.ready        = (state_r == ST_IDLE);
  assign out_item.valid       = (state_r == ST_OUT);
  assign out_item.pixel_index = idx_r;
  assign out_item.pix_red     = pix_r.red;
  assign out_item.pix_green   = pix_r.green;
  assign out_item.pix_blue    = pix_r.blue;
  assign out_item.last_pixel  = last_r;

  always_comb begin
    state_nxt  = state_r;
    offset_nxt = offset_r;
    n_nxt      = n_r;
    mode_nxt   = mode_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    step_nxt   = step_r;
    pix_nxt    = pix_r;
    last_nxt   = last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_item.valid) begin
          n_nxt      = used_n;
          mode_nxt   = in_item.mode;
          fill_nxt   = '{red: in_item.fill_red, green: in_item.fill_green,
                         blue: in_item.fill_blue};
          idx_nxt    = '0;
          rem_nxt    = '0;
          step_nxt   = '0;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? (shifted - {{(PW-CW){1'b0}}, n_r}) : shifted;
        step_nxt = step_r + SW'(1);
        if (step_r == SW'(rwfg_pkg::DIV_STEPS - 1)) begin
          pix_nxt   = (mode_r == rwfg_pkg::MODE_SOLID) ? fill_r : wheel;
          last_nxt  = ({1'b0, idx_r} + CW'(1)) == n_r;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_item.ready) begin
          if (last_r) begin
            if (mode_r == rwfg_pkg::MODE_RAINBOW) begin
              offset_nxt = offset_r + PW'(1);
            end
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + IW'(1);
            rem_nxt   = {{(PW-IW){1'b0}}, idx_r + IW'(1)};
            step_nxt  = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      offset_r      <= '0;
      pixel_count_r <= CW'(rwfg_pkg::MAX_PIXELS);
    end else begin
      state_r  <= state_nxt;
      offset_r <= offset_nxt;
      if (cfg_wr && paddr[2] == rwfg_pkg::REG_PIXEL_COUNT) begin
        pixel_count_r <= pwdata[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    mode_r <= mode_nxt;
    fill_r <= fill_nxt;
    idx_r  <= idx_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= (state_r == ST_DIV) ? quo_nxt : '0;
    step_r <= step_nxt;
    pix_r  <= pix_nxt;
    last_r <= last_nxt;
  end

endmodule

// ===== dv/rainbow_wheel_frame_generator_top_tb.sv =====
// ----------------------------------------------------------------------------
// rainbow_wheel_frame_generator_top_tb: frame generator testbench
// frame requests go in through a valid/ready driver with random gaps, pixel
// items come out to a monitor with random stalls, and each pixel is checked
// against a local color wheel predictor; pixel_count is rewritten over the
// APB port between phases, including zero, saturating and ignored writes
// ----------------------------------------------------------------------------
module rainbow_wheel_frame_generator_top_tb;

  typedef struct {
    logic                       mode;
    logic [rwfg_pkg::LVL_W-1:0] red;
    logic [rwfg_pkg::LVL_W-1:0] green;
    logic [rwfg_pkg::LVL_W-1:0] blue;
  } frame_req_t;

  typedef struct {
    logic [rwfg_pkg::IDX_W-1:0] idx;
    rwfg_pkg::rgb_t             color;
    logic                       last;
  } pixel_t;

  localparam logic [2:0] ADDR_PIXEL_COUNT = 3'd0;
  localparam logic [2:0] ADDR_UNUSED      = 3'd4;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rwfg_in_if  in_item ();
  rwfg_out_if out_item ();

  rainbow_wheel_frame_generator_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  frame_req_t                 frame_reqs[$];
  pixel_t                     pix_expect[$];
  logic [rwfg_pkg::CNT_W-1:0] strip_len;
  logic [rwfg_pkg::POS_W-1:0] wheel_phase;
  int                         errors;
  int                         in_wait;
  int                         out_stall;
  bit                         in_calm;
  bit                         out_calm;

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic rwfg_pkg::rgb_t hue_to_rgb(input int pos);
    int             q;
    rwfg_pkg::rgb_t c;
    q = 255 - (pos % 256);
    if (q < 85) begin
      c.red = 8'(255 - 3 * q); c.green = '0; c.blue = 8'(3 * q);
    end else if (q < 170) begin
      q = q - 85;
      c.red = '0; c.green = 8'(3 * q); c.blue = 8'(255 - 3 * q);
    end else begin
      q = q - 170;
      c.red = 8'(3 * q); c.green = 8'(255 - 3 * q); c.blue = '0;
    end
    return c;
  endfunction

  function automatic void predict_frame(input logic mode,
                                        input logic [rwfg_pkg::LVL_W-1:0] fr,
                                        input logic [rwfg_pkg::LVL_W-1:0] fg,
                                        input logic [rwfg_pkg::LVL_W-1:0] fb);
    int     n;
    pixel_t px;
    n = int'(strip_len);
    if (n == 0) n = 1;
    if (n > rwfg_pkg::MAX_PIXELS) n = rwfg_pkg::MAX_PIXELS;
    for (int i = 0; i < n; i++) begin
      px.idx  = rwfg_pkg::IDX_W'(i);
      px.last = (i + 1 == n);
      if (mode == rwfg_pkg::MODE_RAINBOW) begin
        px.color = hue_to_rgb((i * 256) / n + int'(wheel_phase));
      end else begin
        px.color.red = fr; px.color.green = fg; px.color.blue = fb;
      end
      pix_expect.push_back(px);
    end
    if (mode == rwfg_pkg::MODE_RAINBOW) wheel_phase = wheel_phase + rwfg_pkg::POS_W'(1);
  endfunction

  function automatic int draw_gap(input bit calm);
    if (calm) return 0;
    return $urandom_range(0, 11);
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    frame_req_t req;
    if (!rst_n) begin
      in_item.valid <= 1'b0;
      in_wait       <= 0;
    end else begin
      if (in_item.valid && in_item.ready) begin
        predict_frame(in_item.mode, in_item.fill_red, in_item.fill_green, in_item.fill_blue);
      end
      if (!in_item.valid || in_item.ready) begin
        if (in_wait > 0) begin
          in_wait       <= in_wait - 1;
          in_item.valid <= 1'b0;
        end else if (frame_reqs.size() > 0) begin
          req = frame_reqs.pop_front();
          in_item.mode       <= req.mode;
          in_item.fill_red   <= req.red;
          in_item.fill_green <= req.green;
          in_item.fill_blue  <= req.blue;
          in_item.valid      <= 1'b1;
          in_wait            <= draw_gap(in_calm);
        end else begin
          in_item.valid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor
  always @(posedge clk) begin
    pixel_t px;
    int     k;
    if (!rst_n) begin
      out_item.ready <= 1'b0;
      out_stall      <= 0;
    end else if (out_item.valid && out_item.ready) begin
      if (pix_expect.size() == 0) begin
        $display("%0t unexpected pixel item: expected none, actual index %0d", $time,
                 out_item.pixel_index);
        errors++;
      end else begin
        px = pix_expect.pop_front();
        check_field("pixel_index", px.idx, out_item.pixel_index);
        check_field("pix_red", px.color.red, out_item.pix_red);
        check_field("pix_green", px.color.green, out_item.pix_green);
        check_field("pix_blue", px.color.blue, out_item.pix_blue);
        check_field("last_pixel", px.last, out_item.last_pixel);
      end
      k = draw_gap(out_calm);
      out_item.ready <= (k == 0);
      out_stall      <= k;
    end else if (out_stall > 0) begin
      out_stall      <= out_stall - 1;
      out_item.ready <= (out_stall == 1);
    end else begin
      out_item.ready <= 1'b1;
    end
  end

  task automatic queue_frame(input logic mode, input logic [rwfg_pkg::LVL_W-1:0] fr,
                             input logic [rwfg_pkg::LVL_W-1:0] fg,
                             input logic [rwfg_pkg::LVL_W-1:0] fb);
    frame_req_t req;
    req.mode = mode; req.red = fr; req.green = fg; req.blue = fb;
    frame_reqs.push_back(req);
  endtask

  task automatic queue_random_frame();
    logic mode;
    mode = ($urandom_range(0, 19) == 0) ? rwfg_pkg::MODE_SOLID : rwfg_pkg::MODE_RAINBOW;
    queue_frame(mode, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (frame_reqs.size() != 0 || in_item.valid || pix_expect.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_PIXEL_COUNT) strip_len = data[rwfg_pkg::CNT_W-1:0];
    @(negedge clk);
  endtask

  task automatic csr_read_check();
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_PIXEL_COUNT;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    check_field("prdata", {25'b0, strip_len}, prdata);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int          cnt;
    logic [31:0] wd;
    errors              = 0;
    strip_len           = 7'd64;
    wheel_phase         = '0;
    in_calm             = 1'b0;
    out_calm            = 1'b0;
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_item.valid       = 1'b0;
    in_item.mode        = rwfg_pkg::MODE_RAINBOW;
    in_item.fill_red    = '0;
    in_item.fill_green  = '0;
    in_item.fill_blue   = '0;
    out_item.ready      = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset count of 64, solid extremes
    csr_read_check();
    queue_frame(rwfg_pkg::MODE_RAINBOW, 8'h00, 8'h00, 8'h00);
    queue_frame(rwfg_pkg::MODE_SOLID, 8'h00, 8'h00, 8'h00);
    queue_frame(rwfg_pkg::MODE_SOLID, 8'hFF, 8'hFF, 8'hFF);
    queue_frame(rwfg_pkg::MODE_RAINBOW, 8'hFF, 8'hFF, 8'hFF);
    wait_idle();

    // single pixel strip
    csr_write(ADDR_PIXEL_COUNT, 32'd1);
    queue_frame(rwfg_pkg::MODE_RAINBOW, 8'hA5, 8'h5A, 8'hC3);
    queue_frame(rwfg_pkg::MODE_RAINBOW, 8'h00, 8'h00, 8'h00);
    queue_frame(rwfg_pkg::MODE_SOLID, 8'hAA, 8'h55, 8'h0F);
    wait_idle();

    // zero count is used as one pixel
    csr_write(ADDR_PIXEL_COUNT, 32'hFFFF_FF80);
    csr_read_check();
    queue_frame(rwfg_pkg::MODE_RAINBOW, 8'h00, 8'h00, 8'h00);
    queue_frame(rwfg_pkg::MODE_SOLID, 8'h55, 8'hAA, 8'hF0);
    wait_idle();

    // count above the maximum saturates
    csr_write(ADDR_PIXEL_COUNT, 32'hFFFF_FFFF);
    csr_read_check();
    queue_frame(rwfg_pkg::MODE_RAINBOW, 8'h00, 8'h00, 8'h00);
    wait_idle();
    csr_write(ADDR_PIXEL_COUNT, 32'd65);
    queue_frame(rwfg_pkg::MODE_RAINBOW, 8'h00, 8'h00, 8'h00);
    queue_frame(rwfg_pkg::MODE_SOLID, 8'h12, 8'h34, 8'h56);
    wait_idle();

    // odd count, then a write to an unused register is ignored
    csr_write(ADDR_PIXEL_COUNT, 32'd3);
    queue_frame(rwfg_pkg::MODE_RAINBOW, 8'h00, 8'h00, 8'h00);
    queue_frame(rwfg_pkg::MODE_SOLID, 8'hFF, 8'h00, 8'h5A);
    wait_idle();
    csr_write(ADDR_UNUSED, 32'h0000_0011);
    csr_read_check();
    queue_frame(rwfg_pkg::MODE_RAINBOW, 8'h00, 8'h00, 8'h00);
    queue_frame(rwfg_pkg::MODE_RAINBOW, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // random phases, mostly short strips
    for (int ph = 0; ph < 13; ph++) begin
      if ($urandom_range(0, 3) == 0) csr_write(ADDR_UNUSED, $urandom);
      case ($urandom_range(0, 9))
        0: cnt = $urandom_range(0, 127);
        1, 2: cnt = $urandom_range(9, 64);
        default: cnt = $urandom_range(1, 8);
      endcase
      wd = $urandom;
      wd[rwfg_pkg::CNT_W-1:0] = rwfg_pkg::CNT_W'(cnt);
      csr_write(ADDR_PIXEL_COUNT, wd);
      if ($urandom_range(0, 2) == 0) csr_read_check();
      in_calm  = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      repeat (16) queue_random_frame();
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && pix_expect.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
